>>> src/sqf_pkg.sv
// ----------------------------------------------------------------------------
// sqf_pkg
// shared types and constants for the square-free tester
// ----------------------------------------------------------------------------
package sqf_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;

  typedef enum logic [2:0] {
    DIV_OP_MOD,
    DIV_OP_SQRT,
    DIV_OP_CBRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_M4,
    ST_M4_W,
    ST_M2,
    ST_M2_W,
    ST_M9,
    ST_M9_W,
    ST_M3,
    ST_M3_W,
    ST_SQ,
    ST_SQ_W,
    ST_CB,
    ST_CB_W,
    ST_LOOP,
    ST_PD,
    ST_PD_W,
    ST_PD2,
    ST_PD2_W,
    ST_PSQ,
    ST_PSQ_W,
    ST_PCB,
    ST_PCB_W,
    ST_NEXT,
    ST_DONE
  } sqf_state_t;

endpackage

>>> src/square_free_test.sv
// ----------------------------------------------------------------------------
// square_free_test
// square-free test of one unsigned integer by trial division
// ----------------------------------------------------------------------------
// One request carries an unsigned integer (low VALUE_WIDTH bits used); the
// block answers 1 when no prime square divides it. Values below 4 pass. A
// factor 2 and a factor 3 are stripped (4 or 9 dividing rejects), a perfect
// square remainder rejects, then divisors 5, 7, 11, 13, ... are tried up to
// the floor cube root of the remainder. All arithmetic runs on one shared
// unit that settles one quotient or root bit a cycle: it divides and takes
// floor square roots and floor cube roots. The block takes one request at a
// time; in_tready is low from acceptance until the result has been taken.
// ----------------------------------------------------------------------------
module square_free_test import sqf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] is_square_free, [7:1] zero
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned HW = (W + 1) / 2;

  sqf_state_t   st_r, st_nxt;
  logic [W-1:0] n_r, n_nxt;       // current remainder
  logic [W-1:0] bnd_r, bnd_nxt;   // cube-root bound
  logic [W-1:0] d_r, d_nxt;       // divisor under test
  logic         sec_r, sec_nxt;   // second divisor of the pair
  logic         res_r, res_nxt;
  logic         ov_r, ov_nxt;     // divisor passed representable range

  unit_req_t    ureq;
  logic [W-1:0] ua, ub;
  logic         ubusy;
  logic [W-1:0] uquo, urem;
  logic [2*HW-1:0] sq_prod;
  logic [W-1:0] sq_chk;

  sqf_unit #(.W(W)) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ureq),
    .a    (ua),
    .b    (ub),
    .busy (ubusy),
    .quo  (uquo),
    .rem  (urem)
  );

  // square check: root*root vs remainder, root is at most half width
  assign sq_prod = uquo[HW-1:0] * uquo[HW-1:0];
  assign sq_chk  = W'(sq_prod);

  always_comb begin
    st_nxt     = st_r;
    n_nxt      = n_r;
    bnd_nxt    = bnd_r;
    d_nxt      = d_r;
    sec_nxt    = sec_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r;
    ureq.start = 1'b0;
    ureq.op    = DIV_OP_MOD;
    ua         = n_r;
    ub         = d_r;
    case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n_nxt  = in_tdata[W-1:0];
          st_nxt = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        if (n_r < W'(4)) begin
          res_nxt = 1'b1;
          st_nxt  = ST_DONE;
        end else if (!n_r[0]) begin
          if (!n_r[1]) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            n_nxt  = n_r >> 1;
            st_nxt = ST_M9;
          end
        end else begin
          st_nxt = ST_M9;
        end
      end
      ST_M9: begin
        ureq.start = 1'b1;
        ub         = W'(9);
        st_nxt     = ST_M9_W;
      end
      ST_M9_W: begin
        if (!ubusy) begin
          if (urem == '0) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt = ST_M3;
          end
        end
      end
      ST_M3: begin
        ureq.start = 1'b1;
        ub         = W'(3);
        st_nxt     = ST_M3_W;
      end
      ST_M3_W: begin
        if (!ubusy) begin
          if (urem == '0) n_nxt = uquo;
          st_nxt = ST_M4;
        end
      end
      ST_M4: begin
        if (n_r == W'(1)) begin
          res_nxt = 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          st_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        ureq.start = 1'b1;
        ureq.op    = DIV_OP_SQRT;
        st_nxt     = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (!ubusy) begin
          if (sq_chk == n_r) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt = ST_CB;
          end
        end
      end
      ST_CB: begin
        ureq.start = 1'b1;
        ureq.op    = DIV_OP_CBRT;
        st_nxt     = ST_CB_W;
      end
      ST_CB_W: begin
        if (!ubusy) begin
          bnd_nxt = uquo;
          d_nxt   = W'(5);
          sec_nxt = 1'b0;
          ov_nxt  = 1'b0;
          st_nxt  = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (ov_r || d_r > bnd_r) begin
          res_nxt = 1'b1;
          st_nxt  = ST_DONE;
        end else begin
          st_nxt = ST_PD;
        end
      end
      ST_PD: begin
        ureq.start = 1'b1;
        ub         = sec_r ? d_r + W'(2) : d_r;
        st_nxt     = ST_PD_W;
      end
      ST_PD_W: begin
        if (!ubusy) begin
          if (urem != '0) begin
            st_nxt = ST_NEXT;
          end else begin
            n_nxt  = uquo;
            st_nxt = ST_PD2;
          end
        end
      end
      ST_PD2: begin
        ureq.start = 1'b1;
        ub         = sec_r ? d_r + W'(2) : d_r;
        st_nxt     = ST_PD2_W;
      end
      ST_PD2_W: begin
        if (!ubusy) begin
          if (urem == '0) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt = ST_PSQ;
          end
        end
      end
      ST_PSQ: begin
        ureq.start = 1'b1;
        ureq.op    = DIV_OP_SQRT;
        st_nxt     = ST_PSQ_W;
      end
      ST_PSQ_W: begin
        if (!ubusy) begin
          if (sq_chk == n_r) begin
            res_nxt = 1'b0;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt = ST_PCB;
          end
        end
      end
      ST_PCB: begin
        ureq.start = 1'b1;
        ureq.op    = DIV_OP_CBRT;
        st_nxt     = ST_PCB_W;
      end
      ST_PCB_W: begin
        if (!ubusy) begin
          bnd_nxt = uquo;
          st_nxt  = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!sec_r) begin
          sec_nxt = 1'b1;
          st_nxt  = ST_PD;
        end else begin
          sec_nxt = 1'b0;
          {ov_nxt, d_nxt} = {1'b0, d_r} + (W+1)'(6);
          st_nxt  = ST_LOOP;
        end
      end
      ST_DONE: begin
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r   <= n_nxt;
    bnd_r <= bnd_nxt;
    d_r   <= d_nxt;
    sec_r <= sec_nxt;
    res_r <= res_nxt;
    ov_r  <= ov_nxt;
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_DONE);
  assign out_tdata  = {7'b0, res_r};

endmodule

>>> src/sqf_unit.sv
// ----------------------------------------------------------------------------
// sqf_unit
// shared one-bit-per-cycle unit: divide, floor square root, floor cube root
// ----------------------------------------------------------------------------
module sqf_unit import sqf_pkg::*; #(
  parameter int unsigned W = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  unit_req_t    req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W + 1);
  // roots walk 2-bit and 3-bit groups from the top; pad the operand to a
  // multiple of six so both group sizes line up with bit zero
  localparam int unsigned XW = ((W + 5) / 6) * 6;
  // cube root has XW/3 bits, doubled root needs one more
  localparam int unsigned YW = XW / 3 + 1;

  logic         busy_r, busy_nxt;
  unit_op_t     op_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [W-1:0] d_r;
  logic [W-1:0] y_r, y_nxt;
  logic [W:0]   acc_r, acc_nxt;
  logic [W:0]   trial;
  logic [W+2:0] cacc;
  logic [W+2:0] cb;
  logic [W-1:0] y2;
  logic [YW-1:0] yc, yc1;
  logic [2*YW-1:0] cprod;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    trial    = '0;
    y2       = '0;
    cacc     = '0;
    cb       = '0;
    yc       = '0;
    yc1      = '0;
    cprod    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      x_nxt    = XW'(a);
      y_nxt    = '0;
      acc_nxt  = '0;
      case (req.op)
        DIV_OP_MOD:  cnt_nxt = CW'(W);
        DIV_OP_SQRT: cnt_nxt = CW'(XW / 2);
        DIV_OP_CBRT: cnt_nxt = CW'(XW / 3);
        default:     cnt_nxt = '0;
      endcase
    end else if (busy_r) begin
      case (op_r)
        DIV_OP_MOD: begin
          // restoring division, one quotient bit a cycle
          trial = {acc_r[W-1:0], x_r[W-1]};
          x_nxt = x_r << 1;
          if (trial >= {1'b0, d_r}) begin
            acc_nxt = trial - {1'b0, d_r};
            y_nxt   = {y_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = trial;
            y_nxt   = {y_r[W-2:0], 1'b0};
          end
        end
        DIV_OP_SQRT: begin
          // remainder method: bring two bits down, try 4y+1
          trial = {acc_r[W-2:0], x_r[XW-1 -: 2]};
          x_nxt = x_r << 2;
          y2    = {y_r[W-3:0], 2'b01};
          if (trial >= {1'b0, y2}) begin
            acc_nxt = trial - {1'b0, y2};
            y_nxt   = {y_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = trial;
            y_nxt   = {y_r[W-2:0], 1'b0};
          end
        end
        DIV_OP_CBRT: begin
          // remainder method: bring three bits down
          // with y' = 2y, need 3y'(y'+1)+1 in the group scale
          cacc  = {acc_r[W-1:0], x_r[XW-1 -: 3]};
          y2    = y_r << 1;
          yc    = YW'(y2);
          yc1   = yc + YW'(1);
          cprod = yc * yc1;
          cb    = ((W+3)'(cprod) << 1) + (W+3)'(cprod) + (W+3)'(1);
          x_nxt = x_r << 3;
          if (cacc >= cb) begin
            acc_nxt = (W+1)'(cacc - cb);
            y_nxt   = y2 | W'(1);
          end else begin
            acc_nxt = (W+1)'(cacc);
            y_nxt   = y2;
          end
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    if (req.start) begin
      op_r <= req.op;
      d_r  <= b;
    end
  end

  assign busy = busy_r;
  assign quo  = y_r;
  assign rem  = acc_r[W-1:0];

endmodule

>>> src/sqf_checker.sv
// ----------------------------------------------------------------------------
// sqf_checker
// port-level checks for the square-free tester
// ----------------------------------------------------------------------------
module sqf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // one request in flight: no acceptance while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");

  // an accepted request does not produce a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped");

  // padding bits are zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] == 7'b0)) else $error("padding set");

endmodule

bind square_free_test sqf_checker u_sqf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> tb/sv/tb_square_free_test.sv
// ----------------------------------------------------------------------------
// tb_square_free_test
// self-checking testbench for the square-free tester
// ----------------------------------------------------------------------------
// Requests go in on the in_ stream, one 64-bit value each. The expected verdict
// is computed by a behavioral trial-division model at the moment of
// acceptance and queued. Each result on the out_ stream is checked against
// the oldest queued verdict. Values are chosen so that the trial loop ends
// early: small numbers, multiples of prime squares, perfect squares and smooth
// products. Those that would run to the full cube-root bound of a 64-bit
// value are left out.
// ----------------------------------------------------------------------------
module tb_square_free_test;
  import sqf_pkg::*;

  localparam int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned N_RANDOM    = 70;
  localparam int unsigned LONG_HOLD   = 3000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;    // [63:0] value
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [0] is_square_free, [7:1] zero

  // verdicts still owed by the block, oldest first
  bit          verdict_q[$];
  int unsigned n_errors;
  int unsigned cycle_cnt;

  // sender burst state
  int unsigned burst_left;

  // receiver hold-off, requested from the test sequence
  int unsigned hold_req;
  int unsigned hold_cnt;
  int unsigned ready_run;
  bit          ready_phase;

  square_free_test #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // behavioral model
  // --------------------------------------------------------------------------

  // floor square root by binary search, exact for any 64-bit value
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // floor cube root; 2642245 is the largest cube base below 2**64
  function automatic longint unsigned floor_cbrt(longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd2642245;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (mid * mid * mid <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic bit is_perfect_square(longint unsigned x);
    longint unsigned r;
    r = floor_sqrt(x);
    return r * r == x;
  endfunction

  // one trial divisor: a hit divides once, then a repeated factor or a
  // square cofactor means a square divides; otherwise the bound shrinks
  function automatic bit divisor_finds_square(ref longint unsigned rest,
                                              ref longint unsigned limit,
                                              input longint unsigned d);
    if (rest % d != 0) return 1'b0;
    rest = rest / d;
    if (rest % d == 0) return 1'b1;
    if (is_perfect_square(rest)) return 1'b1;
    limit = floor_cbrt(rest);
    return 1'b0;
  endfunction

  function automatic bit predict_square_free(logic [63:0] raw);
    longint unsigned n;
    longint unsigned limit;
    longint unsigned d;
    n = raw;
    if (VALUE_WIDTH < 64) n = n & ((64'd1 << VALUE_WIDTH) - 1);
    if (n < 4) return 1'b1;
    if (n % 2 == 0) begin
      if (n % 4 == 0) return 1'b0;
      n = n / 2;
    end
    if (n % 3 == 0) begin
      if (n % 9 == 0) return 1'b0;
      n = n / 3;
    end
    if (n == 1) return 1'b1;
    if (is_perfect_square(n)) return 1'b0;
    limit = floor_cbrt(n);
    // divisors 6k-1 and 6k+1 tried as a pair
    for (d = 5; d <= limit; d += 6) begin
      if (divisor_finds_square(n, limit, d)) return 1'b0;
      if (divisor_finds_square(n, limit, d + 2)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // sender: one request, valid kept high across a burst
  // --------------------------------------------------------------------------
  task automatic send_value(logic [63:0] v);
    in_tdata  <= v;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    verdict_q.push_back(predict_square_free(v));
    @(negedge clk);
    if (burst_left == 0) begin
      // end of burst: drop valid and idle a random while
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver: alternating ready and stall runs, plus an optional long hold
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      if (ready_run == 0) begin
        ready_phase = ~ready_phase;
        ready_run   = ready_phase ? $urandom_range(1, 20) : $urandom_range(0, 8);
      end else begin
        ready_run--;
      end
      out_tready <= ready_phase;
    end
  end

  // --------------------------------------------------------------------------
  // result check, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        n_errors++;
      end else begin
        bit want;
        want = verdict_q.pop_front();
        if (out_tdata[0] !== want) begin
          $display("%0t: is_square_free mismatch, expected %0d, actual %b",
                   $time, want, out_tdata[0]);
          n_errors++;
        end
        if (out_tdata[7:1] !== 7'd0) begin
          $display("%0t: padding bits mismatch, expected 0, actual %h",
                   $time, out_tdata[7:1]);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // value generators that keep the trial loop short
  // --------------------------------------------------------------------------

  // product of random small primes, 2 and 3 at most once each sometimes
  function automatic logic [63:0] smooth_value();
    int unsigned primes[13] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    longint unsigned prod;
    int unsigned p;
    prod = 1;
    if ($urandom_range(0, 1)) prod = prod * 2;
    if ($urandom_range(0, 1)) prod = prod * 3;
    for (int k = 0; k < 20; k++) begin
      p = primes[$urandom_range(0, 12)];
      if (prod < 64'hFFFF_FFFF_FFFF_FFFF / 47) prod = prod * p;
    end
    return prod;
  endfunction

  function automatic logic [63:0] structured_value();
    logic [63:0] x;
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} & ~64'd3;                 // multiple of 4
      1: begin
        x = {$urandom, $urandom} >> 4;                          // 9 times x
        return x * 9;
      end
      2: begin
        x = {$urandom, $urandom} >> 5;                          // 25 times x
        return x * 25;
      end
      3: begin
        x = {32'd0, $urandom};                                  // perfect square
        return x * x;
      end
      4:       return smooth_value();
      default: return {40'd0, 24'($urandom)};                   // small value
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // values below 4 and the stripping of factors 2 and 3
  task automatic test_small_cases();
    logic [63:0] vals[14] = '{0, 1, 2, 3, 4, 5, 6, 8, 9, 12, 15, 18, 30, 30030};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  // repeated factors found in the trial loop and square cofactors
  task automatic test_trial_loop();
    send_value(64'd25);
    send_value(64'd49 * 11);
    send_value(64'd121 * 13);
    send_value(64'd5 * 7 * 7 * 7);
    send_value(64'd2 * 5 * 13 * 13);
    send_value(64'd614889782588491410);   // primorial up to 47
  endtask

  // large values, up to the top of the value range
  task automatic test_extremes();
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'hFFFF_FFFF_FFFF_FFFC);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'd4294967291 * 64'd4294967291);   // square of a large prime
    send_value(64'hFFFF_FFFF_FFFF_FFFE);
  endtask

  task automatic test_random_values();
    for (int unsigned k = 0; k < N_RANDOM; k++) send_value(structured_value());
  endtask

  // receiver stalls a long stretch while requests keep coming
  task automatic test_output_hold();
    hold_req = LONG_HOLD;
    for (int k = 0; k < 6; k++) send_value(structured_value());
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    n_errors    = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    hold_req    = 0;
    hold_cnt    = 0;
    ready_run   = 0;
    ready_phase = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_small_cases();
    test_trial_loop();
    test_extremes();
    test_output_hold();
    test_random_values();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> square_free_test.f
src/sqf_pkg.sv
src/sqf_unit.sv
src/square_free_test.sv
src/sqf_checker.sv
tb/sv/tb_square_free_test.sv
